FILE: rtl/ste_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stego-table embedder package
// Shared constants, request kinds and sequencer types of the embedder.
// ----------------------------------------------------------------------------
package ste_pkg;

	// Default number of 64-bit words in the table store.
	localparam int TABLE_WORDS_DEF = 8;
	// Highest intensity level, integer part.
	localparam int MAX_LEVEL = 255;
	// Interval width after reset.
	localparam logic [7:0] K_RESET = 8'd8;
	// Highest intensity in 8.8 fixed point.
	localparam logic [16:0] LIMIT = 17'(MAX_LEVEL * 256);

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_EMBED   = 2'd1,
		KIND_EXTRACT = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	// What the current table lookup is for.
	typedef enum logic [1:0] {
		PH_FIX,
		PH_CAND,
		PH_CHECK
	} phase_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_LDIV,
		S_LEN,
		S_IRD0,
		S_IRD1,
		S_IRD2,
		S_TDIV,
		S_LK,
		S_XDIV,
		S_LA,
		S_LB,
		S_CAND,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/ste_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stego-table embedder channels
// Valid/ready channels for requests and results of the embedder.
// ----------------------------------------------------------------------------
interface ste_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] intensity;
	logic        wanted_bit;
	logic [2:0]  word_select;
	logic [63:0] word_value;

	modport source (output valid, kind, intensity, wanted_bit, word_select, word_value,
		input ready);
	modport sink (input valid, kind, intensity, wanted_bit, word_select, word_value,
		output ready);
endinterface

interface ste_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] new_intensity;
	logic        read_bit;
	logic        failed;

	modport source (output valid, new_intensity, read_bit, failed, input ready);
	modport sink (input valid, new_intensity, read_bit, failed, output ready);
endinterface
`default_nettype wire

FILE: rtl/ste_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ste_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/stego_table_intensity_embedder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stego-table intensity embedder
// Hides or reads one bit per 8.8 mean intensity through rotating tables.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A load, an unused kind, or any embed or
// extract while the interval width is zero goes from acceptance to the done
// state and from there into the output register. Embed and extract requests run
// through a shared divider that yields one quotient bit per cycle (nine steps
// per division) and a table RAM with one read port and a registered read:
// the row length, the index entry and every table lookup each take a division,
// and a lookup then reads the RAM in states S_LA and S_LB. No index entry is
// read when the cursor lands beyond the last index entry. How long an embed
// runs also depends on how many of the four neighbouring intervals are searched.
// The request side is ready again as soon as the result sits in the output
// register.
module stego_table_intensity_embedder
	import ste_pkg::*;
#(
	parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	ste_req_if.sink         request,
	ste_res_if.source       result
);

	localparam int AW = $clog2(TABLE_WORDS);

	state_t state_q, state_d;
	phase_t phase_q;

	logic [7:0]  k_q;
	logic [5:0]  cur_q;
	kind_t       kind_q;
	logic [15:0] fix_q;
	logic [15:0] cand_q;
	logic        want_q;
	logic [8:0]  len_q;
	logic [7:0]  t_q;
	logic [7:0]  idx_q;
	logic [9:0]  pos_q;
	logic [5:0]  off_q;
	logic [3:0]  w0_q;
	logic        first_q;
	logic [63:0] word0_q;
	logic [2:0]  ci_q;
	logic        rd_ok_q;
	logic [15:0] pn_int_q;
	logic        pn_bit_q;
	logic        pn_fail_q;
	logic        ov_q;
	logic [15:0] o_int_q;
	logic        o_bit_q;
	logic        o_fail_q;

	// Divider registers.
	logic [7:0] dv_r_q;
	logic [8:0] dv_n_q;
	logic [3:0] dv_cnt_q;
	logic       dv_done;
	logic       dv_load;
	logic [8:0] dv_dividend;
	logic [8:0] dv_trial;
	logic       dv_ge;

	logic        acc;
	logic        out_free;
	logic [4:0]  sel_ext;
	logic        ram_we;
	logic [3:0]  rd_word;
	logic [4:0]  rd_ext;
	logic [63:0] ram_rdata;
	logic [63:0] rdm;

	logic [9:0]   total;
	logic [6:0]   n_ent;
	logic [6:0]   eth;
	logic [6:0]   c_inc;
	logic [5:0]   c_next;
	logic [9:0]   s_pos;
	logic [127:0] win_sh;
	logic [8:0]   ebits;
	logic [8:0]   ebits_rev;
	logic [8:0]   ent_val;
	logic         lk_bit;
	logic         match;
	logic [15:0]  mk;
	logic [16:0]  mid;
	logic [15:0]  mid_fix;
	logic [15:0]  mid_cand;
	logic [8:0]   ik;
	logic [16:0]  step17;
	logic [16:0]  fix17;
	logic [16:0]  cdown;
	logic [17:0]  cup;
	logic         c_ok;
	logic [15:0]  c_val;

	assign acc      = request.valid && request.ready;
	assign out_free = !ov_q || result.ready;
	assign dv_done  = (dv_cnt_q == 4'd0);

	// Table store.
	assign sel_ext = 5'(request.word_select);
	assign ram_we  = acc && (request.kind == KIND_LOAD) && (sel_ext < 5'(TABLE_WORDS));
	assign rd_ext  = 5'(rd_word);

	ste_ram #(
		.WIDTH(64),
		.DEPTH(TABLE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sel_ext[AW-1:0]),
		.wdata (request.word_value),
		.raddr (rd_ext[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Words beyond the store read as zero.
	assign rdm = ram_rdata & {64{rd_ok_q}};

	// Row length product, entry count and next cursor.
	assign total  = 10'(len_q * k_q);
	assign n_ent  = total[9:3];
	assign eth    = 7'((total - 10'd1) >> 3);
	assign c_inc  = {1'b0, cur_q} + 7'd1;
	assign c_next = (c_inc >= n_ent) ? 6'd0 : c_inc[5:0];
	assign s_pos  = (c_next == 6'd0) ? 10'd0 : ({1'b0, c_next, 3'b000} + 10'd1);

	// Index entry bits, taken most significant first.
	assign win_sh = {rdm, word0_q} >> off_q;
	assign ebits  = win_sh[8:0];
	always_comb begin
		for (int j = 0; j < 9; j++) begin
			ebits_rev[8-j] = ebits[j];
		end
	end
	assign ent_val = first_q ? ebits_rev : {1'b0, ebits_rev[8:1]};

	// Lookup bit and interval middle.
	assign lk_bit   = rdm[pos_q[5:0]];
	assign match    = (lk_bit == want_q);
	assign mk       = idx_q * k_q;
	assign mid      = (17'(mk) << 8) + (17'(k_q) << 7);
	assign mid_fix  = mid[16] ? LIMIT[15:0] : mid[15:0];
	assign mid_cand = (mid > LIMIT) ? LIMIT[15:0] : mid[15:0];

	// Neighbouring candidate: -k, +k, -2k, +2k.
	assign ik     = ci_q[1] ? {k_q, 1'b0} : {1'b0, k_q};
	assign step17 = {ik, 8'd0};
	assign fix17  = {1'b0, fix_q};
	assign cdown  = fix17 - step17;
	assign cup    = {1'b0, fix17} + {1'b0, step17};
	assign c_ok   = ci_q[0] ? (cup <= {1'b0, LIMIT}) : (fix17 >= step17);
	assign c_val  = ci_q[0] ? cup[15:0] : cdown[15:0];

	// Divider step.
	assign dv_trial = {dv_r_q, dv_n_q[8]};
	assign dv_ge    = (dv_trial >= {1'b0, k_q});

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM read address and divider start.
	always_comb begin
		state_d       = state_q;
		request.ready = 1'b0;
		rd_word       = 4'd0;
		dv_load       = 1'b0;
		dv_dividend   = 9'd0;
		case (state_q)
			S_IDLE: begin
				request.ready = 1'b1;
				if (request.valid) begin
					if (request.kind == KIND_LOAD || request.kind == KIND_NONE ||
						k_q == 8'd0) begin
						state_d = S_DONE;
					end else begin
						dv_load     = 1'b1;
						dv_dividend = 9'(k_q) + 9'd254;
						state_d     = S_LDIV;
					end
				end
			end
			S_LDIV: begin
				if (dv_done) begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				state_d = ({1'b0, c_next} >= eth) ? S_LK : S_IRD0;
			end
			S_IRD0: begin
				rd_word = w0_q;
				state_d = S_IRD1;
			end
			S_IRD1: begin
				rd_word = w0_q + 4'd1;
				state_d = S_IRD2;
			end
			S_IRD2: begin
				dv_load     = 1'b1;
				dv_dividend = ent_val;
				state_d     = S_TDIV;
			end
			S_TDIV: begin
				if (dv_done) begin
					state_d = S_LK;
				end
			end
			S_LK: begin
				dv_load     = 1'b1;
				dv_dividend = {1'b0, cand_q[15:8]};
				state_d     = S_XDIV;
			end
			S_XDIV: begin
				if (dv_done) begin
					state_d = S_LA;
				end
			end
			S_LA: begin
				rd_word = pos_q[9:6];
				state_d = S_LB;
			end
			S_LB: begin
				if (kind_q == KIND_EXTRACT || phase_q == PH_CHECK) begin
					state_d = S_DONE;
				end else if (match) begin
					state_d = S_LK;
				end else begin
					state_d = S_CAND;
				end
			end
			S_CAND: begin
				if (ci_q == 3'd4) begin
					state_d = S_DONE;
				end else if (c_ok) begin
					state_d = S_LK;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers: interval width, cursor, divider count, output valid, read-in-range flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= K_RESET;
			cur_q    <= 6'd0;
			dv_cnt_q <= 4'd0;
			ov_q     <= 1'b0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				k_q <= cfg_wr_data;
			end
			if (acc && request.kind == KIND_LOAD) begin
				cur_q <= 6'd0;
			end else if (state_q == S_LEN) begin
				cur_q <= c_next;
			end
			if (dv_load) begin
				dv_cnt_q <= 4'd9;
			end else if (!dv_done) begin
				dv_cnt_q <= dv_cnt_q - 4'd1;
			end
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			rd_ok_q <= (rd_ext < 5'(TABLE_WORDS));
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Shared restoring divider, one quotient bit per cycle.
		if (dv_load) begin
			dv_r_q <= 8'd0;
			dv_n_q <= dv_dividend;
		end else if (!dv_done) begin
			dv_r_q <= dv_ge ? 8'(dv_trial - {1'b0, k_q}) : dv_trial[7:0];
			dv_n_q <= {dv_n_q[7:0], dv_ge};
		end

		case (state_q)
			S_IDLE: begin
				kind_q    <= kind_t'(request.kind);
				fix_q     <= request.intensity;
				cand_q    <= request.intensity;
				want_q    <= request.wanted_bit;
				phase_q   <= PH_FIX;
				t_q       <= 8'd0;
				pn_int_q  <= 16'd0;
				pn_bit_q  <= 1'b0;
				pn_fail_q <= (request.kind != KIND_LOAD) && (request.kind != KIND_NONE) &&
					(k_q == 8'd0);
			end
			S_LDIV: begin
				// Row length rounded up to even.
				len_q <= dv_n_q + {8'd0, dv_n_q[0]};
			end
			S_LEN: begin
				off_q   <= s_pos[5:0];
				w0_q    <= s_pos[9:6];
				first_q <= (c_next == 6'd0);
			end
			S_IRD1: begin
				word0_q <= rdm;
			end
			S_TDIV: begin
				t_q <= dv_r_q;
			end
			S_XDIV: begin
				idx_q <= dv_n_q[7:0];
				pos_q <= 10'(t_q * len_q) + 10'(dv_n_q[7:0]);
			end
			S_LB: begin
				if (kind_q == KIND_EXTRACT) begin
					pn_bit_q <= lk_bit;
				end else if (phase_q == PH_CHECK) begin
					pn_int_q  <= match ? cand_q : 16'd0;
					pn_fail_q <= !match;
				end else if (match) begin
					cand_q  <= (phase_q == PH_FIX) ? mid_fix : mid_cand;
					phase_q <= PH_CHECK;
				end else begin
					ci_q <= (phase_q == PH_FIX) ? 3'd0 : ci_q + 3'd1;
				end
			end
			S_CAND: begin
				if (ci_q == 3'd4) begin
					pn_fail_q <= 1'b1;
				end else if (c_ok) begin
					cand_q  <= c_val;
					phase_q <= PH_CAND;
				end else begin
					ci_q <= ci_q + 3'd1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					o_int_q  <= pn_int_q;
					o_bit_q  <= pn_bit_q;
					o_fail_q <= pn_fail_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid         = ov_q;
	assign result.new_intensity = o_int_q;
	assign result.read_bit      = o_bit_q;
	assign result.failed        = o_fail_q;

	// A load always restarts the rotation.
	a_load_clears_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && request.kind == KIND_LOAD) |=> (cur_q == 6'd0))
		else $error("cursor not cleared after a load");

	// A failed result carries no intensity and no bit.
	a_fail_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.failed) |-> (result.new_intensity == 16'd0 && !result.read_bit))
		else $error("failed result carries data");

	// The divider is never restarted while still running a division.
	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dv_load |-> dv_done)
		else $error("divider restarted while busy");

	// No request is taken while a result is still being formed.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		request.ready |-> (dv_done && state_q == S_IDLE))
		else $error("request side ready while busy");

endmodule
`default_nettype wire

FILE: sim/tb_stego_table_intensity_embedder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stego-table intensity embedder testbench
// Drives load, embed, extract and unused-kind requests with random gaps and result stalls.
// Every result is checked against a bit-true predictor kept in a scoreboard.
// The interval width is swept over values from 0 to 255, both ends included, between phases.
// ----------------------------------------------------------------------------
module tb_stego_table_intensity_embedder;
	import ste_pkg::*;

	// Expected outcome of one request.
	typedef struct packed {
		logic [15:0] new_intensity;
		logic        read_bit;
		logic        failed;
	} outcome_t;

	// Predictor of the embedder together with the queue of expected outcomes.
	class intensity_scoreboard;
		logic [63:0] words [8];
		bit   [5:0]  cursor;
		bit   [7:0]  width_k;
		outcome_t    awaited_q [$];
		int          mismatches;
		int          checked;
		int          failures_seen;
		int          embeds;
		int          extracts;

		function new();
			cursor = '0;
			width_k = K_RESET;
			mismatches = 0;
			checked = 0;
			failures_seen = 0;
			embeds = 0;
			extracts = 0;
		endfunction

		function int unsigned row_len(int unsigned kk);
			int unsigned len;
			len = (255 + kk - 1) / kk;
			if (len[0])
				len++;
			return len;
		endfunction

		function int unsigned flat_bit(int unsigned pos);
			if (pos >= 512)
				return 0;
			return 32'(words[pos >> 6][pos & 63]);
		endfunction

		// Index entry p, read MSB first from the flattened bits.
		function int unsigned index_entry(int unsigned p, int unsigned kk,
				int unsigned total);
			int unsigned first, count, v;
			v = 0;
			if (p >= (total - 1) / 8)
				return 0;
			first = (p == 0) ? 0 : 8 * p + 1;
			count = (p == 0) ? 9 : 8;
			for (int unsigned j = 0; j < count; j++)
				v = (v << 1) | flat_bit(first + j);
			return v % kk;
		endfunction

		// Step the rotation cursor and return the selected table.
		function int unsigned rotate_table(int unsigned kk);
			int unsigned total, n, c;
			total = row_len(kk) * kk;
			n = total / 8;
			c = cursor + 1;
			if (c >= n)
				c = 0;
			cursor = c[5:0];
			return index_entry(cursor, kk, total);
		endfunction

		function int unsigned table_bit(int unsigned fix, int unsigned t, int unsigned kk);
			return flat_bit(t * row_len(kk) + fix / (256 * kk));
		endfunction

		function int unsigned interval_middle(int unsigned fix, int unsigned kk);
			return (fix / (256 * kk)) * kk * 256 + kk * 128;
		endfunction

		// Works out the outcome of one request and updates the state.
		function outcome_t predict(kind_t kind, bit [15:0] fix, bit want,
				bit [2:0] sel, bit [63:0] value);
			outcome_t o;
			int unsigned kk, t, m, stp, lim;
			int unsigned cand [2];
			bit ok [2];
			o = '0;
			kk = width_k;
			lim = MAX_LEVEL * 256;
			if (kind == KIND_LOAD) begin
				words[sel] = value;
				cursor = '0;
				return o;
			end
			if (kind == KIND_NONE)
				return o;
			if (kk == 0) begin
				o.failed = 1'b1;
				return o;
			end
			t = rotate_table(kk);
			if (kind == KIND_EXTRACT) begin
				extracts++;
				o.read_bit = 1'(table_bit(fix, t, kk));
				return o;
			end
			embeds++;
			// The bit already matches: move to the middle of the own interval.
			if (table_bit(fix, t, kk) == want) begin
				m = interval_middle(fix, kk);
				if (m > 16'hFFFF)
					m = lim;
				if (table_bit(m, t, kk) != want)
					o.failed = 1'b1;
				else
					o.new_intensity = m[15:0];
				return o;
			end
			// Search the neighbouring intervals, nearest first, downward first.
			for (int unsigned i = 1; i < 3; i++) begin
				stp = i * kk * 256;
				ok[0] = fix >= stp;
				cand[0] = ok[0] ? fix - stp : 0;
				cand[1] = fix + stp;
				ok[1] = cand[1] <= lim;
				for (int s = 0; s < 2; s++) begin
					if (ok[s] && table_bit(cand[s], t, kk) == want) begin
						m = interval_middle(cand[s], kk);
						if (m > lim)
							m = lim;
						if (table_bit(m, t, kk) != want)
							o.failed = 1'b1;
						else
							o.new_intensity = m[15:0];
						return o;
					end
				end
			end
			o.failed = 1'b1;
			return o;
		endfunction

		function void note_request(kind_t kind, bit [15:0] fix, bit want,
				bit [2:0] sel, bit [63:0] value);
			awaited_q.push_back(predict(kind, fix, want, sel, value));
		endfunction

		function void check_result(logic [15:0] ni, logic rb, logic fl);
			outcome_t exp_o;
			checked++;
			if (fl === 1'b1)
				failures_seen++;
			if (awaited_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: new_intensity=%h read_bit=%b failed=%b",
						ni, rb, fl);
				return;
			end
			exp_o = awaited_q.pop_front();
			if (ni !== exp_o.new_intensity || rb !== exp_o.read_bit
					|| fl !== exp_o.failed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch at %0t: expected ni=%h rb=%b fl=%b, got ni=%h rb=%b fl=%b",
						$realtime, exp_o.new_intensity, exp_o.read_bit, exp_o.failed,
						ni, rb, fl);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	bit         burst;

	ste_req_if req_if ();
	ste_res_if res_if ();

	intensity_scoreboard sb;

	stego_table_intensity_embedder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.request     (req_if),
		.result      (res_if)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#8000000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: random stalls, then check every accepted result.
	initial begin
		int stall;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
			sb.check_result(res_if.new_intensity, res_if.read_bit, res_if.failed);
		end
	end

	// Sends one request after a random gap and notes it once accepted.
	task automatic send_request(kind_t kind, bit [15:0] fix, bit want, bit [2:0] sel,
			bit [63:0] value);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.kind        <= kind;
		req_if.intensity   <= fix;
		req_if.wanted_bit  <= want;
		req_if.word_select <= sel;
		req_if.word_value  <= value;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sb.note_request(kind, fix, want, sel, value);
	endtask

	// Stops sending and waits until every expected result has come.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (sb.awaited_q.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Writes the interval width while the block is idle.
	task automatic set_interval(bit [7:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.width_k = value;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [15:0] pick_intensity();
		case ($urandom_range(0, 4))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(16'hF000, 16'hFFFF));
			3: return 16'($urandom_range(0, 16'h0800));
			default: return {8'($urandom), 8'h00};
		endcase
	endfunction

	// One random request: mostly embed and extract, with occasional reloads.
	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			send_request(KIND_LOAD, 16'($urandom), 1'($urandom), 3'($urandom),
				{$urandom, $urandom});
		else if (r < 6)
			send_request(KIND_NONE, 16'($urandom), 1'($urandom), 3'($urandom),
				{$urandom, $urandom});
		else if (r < 55)
			send_request(KIND_EMBED, pick_intensity(), 1'($urandom), 3'($urandom),
				{$urandom, $urandom});
		else
			send_request(KIND_EXTRACT, pick_intensity(), 1'($urandom), 3'($urandom),
				{$urandom, $urandom});
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			random_request();
		end
		burst = 1'b0;
	endtask

	// Main sequence.
	initial begin
		bit [7:0] widths [9];
		sb = new();
		burst = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_LOAD;
		req_if.intensity = '0;
		req_if.wanted_bit = 1'b0;
		req_if.word_select = '0;
		req_if.word_value = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: fill the whole store first, with extreme patterns in the first four words.
		send_request(KIND_LOAD, 16'h0000, 1'b0, 3'd0, 64'h0);
		send_request(KIND_LOAD, 16'hFFFF, 1'b1, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(KIND_LOAD, 16'h0000, 1'b0, 3'd2, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(KIND_LOAD, 16'h0000, 1'b0, 3'd3, 64'h5555_5555_5555_5555);
		for (int w = 4; w < 8; w++)
			send_request(KIND_LOAD, 16'h0000, 1'b0, 3'(w), {$urandom, $urandom});
		send_request(KIND_EMBED, 16'h0000, 1'b0, 3'd0, 64'h0);
		send_request(KIND_EMBED, 16'h0000, 1'b1, 3'd0, 64'h0);
		send_request(KIND_EMBED, 16'hFFFF, 1'b0, 3'd7, 64'h0);
		send_request(KIND_EMBED, 16'hFFFF, 1'b1, 3'd7, 64'h0);
		send_request(KIND_EMBED, 16'hFF00, 1'b1, 3'd0, 64'h0);
		send_request(KIND_EMBED, 16'hFA80, 1'b0, 3'd0, 64'h0);
		send_request(KIND_EXTRACT, 16'h0000, 1'b0, 3'd0, 64'h0);
		send_request(KIND_EXTRACT, 16'hFFFF, 1'b1, 3'd0, 64'h0);
		send_request(KIND_NONE, 16'hFFFF, 1'b1, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(KIND_EXTRACT, 16'h0800, 1'b0, 3'd0, 64'h0);
		for (int w = 0; w < 8; w++)
			send_request(KIND_LOAD, 16'h0000, 1'b0, 3'(w), {$urandom, $urandom});

		// Random phases over a sweep of interval widths, the reset width first.
		widths = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd17, 8'd128, 8'd5, 8'd0};
		widths[8] = 8'($urandom_range(4, 64));
		random_phase(450);
		foreach (widths[i]) begin
			set_interval(widths[i]);
			if (widths[i] == 0)
				random_phase(30);
			else begin
				random_phase(90);
				// Hold the sender until the block has caught up completely.
				drain_results();
				random_phase(90);
			end
		end

		drain_results();
		repeat (150) @(posedge clk);
		if (sb.awaited_q.size() != 0) begin
			sb.mismatches += sb.awaited_q.size();
			$display("%0d expected results never arrived", sb.awaited_q.size());
		end
		$display("Checked %0d results (%0d embeds, %0d extracts, %0d failure flags).",
			sb.checked, sb.embeds, sb.extracts, sb.failures_seen);
		$display("Interval widths swept from 0 to 255; %0d mismatches.", sb.mismatches);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/ste_pkg.sv
rtl/ste_if.sv
rtl/ste_ram.sv
rtl/stego_table_intensity_embedder.sv
sim/tb_stego_table_intensity_embedder.sv
